/* sv/tree_packet_router_defines.svh */
// Assertion macros used by the tree packet router slot RTL.
`ifndef TREE_PACKET_ROUTER_DEFINES_SVH
`define TREE_PACKET_ROUTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPR_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tpr_pkg.sv */
// Types, constants and helper functions for the tree packet router.
`default_nettype none

package tpr_pkg;

  localparam int DIGITS = 5;
  localparam int SLOT_NUM_W = 3;
  localparam logic [15:0] LEVEL_MASK_BASE = 16'hFFFE;
  localparam logic [7:0] PAD_BYTE = 8'hF0;
  localparam logic [39:0] BROADCAST_PIPE = 40'hF0F0F0F0FE;

  typedef enum logic [1:0] {
    CMD_DATA       = 2'd0,
    CMD_CHILD_REQ  = 2'd1,
    CMD_MEMBER_REQ = 2'd2,
    CMD_CONFIRM    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_LOCAL      = 3'd0,
    ACT_CHILD      = 3'd1,
    ACT_PARENT     = 3'd2,
    ACT_GRANT      = 3'd3,
    ACT_NO_SLOT    = 3'd4,
    ACT_CONFIRMED  = 3'd5,
    ACT_ADDR_ERROR = 3'd6
  } action_t;

  typedef enum logic {
    REG_NODE_ADDRESS = 1'b0,
    REG_NODE_LEVEL   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] dest_addr;
    logic [15:0] src_addr;
    logic [1:0]  slot;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic [2:0]  pipe_index;
    logic [39:0] pipe_address;
    logic [15:0] granted_addr;
    logic [2:0]  granted_level;
    logic [1:0]  granted_member;
    logic        children_open;
    logic        members_open;
  } result_t;

  typedef struct packed {
    logic       child_req;
    logic       member_req;
    logic       confirm;
    logic       confirm_member;
    logic [1:0] slot;
  } slot_upd_t;

  typedef struct packed {
    logic [SLOT_NUM_W-1:0] child_free;
    logic [SLOT_NUM_W-1:0] member_free;
    logic                  child_open;
    logic                  member_open;
  } slot_stat_t;

  function automatic logic [2:0] mod6_add(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd12) begin
      s = s - 4'd12;
    end else if (s >= 4'd6) begin
      s = s - 4'd6;
    end
    return s[2:0];
  endfunction

  function automatic logic [7:0] seg_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'hF0;
      3'd1: b = 8'hE1;
      3'd2: b = 8'hD2;
      3'd3: b = 8'hC3;
      3'd4: b = 8'hB4;
      3'd5: b = 8'hA5;
      default: b = 8'hF0;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] digit_at(input logic [15:0] a, input logic [2:0] d);
    logic [2:0] r;
    case (d)
      3'd0: r = a[15:13];
      3'd1: r = a[12:10];
      3'd2: r = a[9:7];
      3'd3: r = a[6:4];
      3'd4: r = a[3:1];
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/tpr_in_if.sv */
// Packet input channel of the tree packet router.
`default_nettype none

interface tpr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] dest_addr;
  logic [15:0] src_addr;
  logic [1:0]  slot;

  modport source (output valid, output cmd, output dest_addr, output src_addr,
                  output slot, input ready);
  modport sink (input valid, input cmd, input dest_addr, input src_addr,
                input slot, output ready);
endinterface

`default_nettype wire

/* sv/tpr_out_if.sv */
// Result output channel of the tree packet router.
`default_nettype none

interface tpr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  pipe_index;
  logic [39:0] pipe_address;
  logic [15:0] granted_addr;
  logic [2:0]  granted_level;
  logic [1:0]  granted_member;
  logic        children_open;
  logic        members_open;

  modport source (output valid, output action, output pipe_index, output pipe_address,
                  output granted_addr, output granted_level, output granted_member,
                  output children_open, output members_open, input ready);
  modport sink (input valid, input action, input pipe_index, input pipe_address,
                input granted_addr, input granted_level, input granted_member,
                input children_open, input members_open, output ready);
endinterface

`default_nettype wire

/* sv/tpr_cfg_if.sv */
// Configuration write channel of the tree packet router.
`default_nettype none

interface tpr_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/tpr_pipe_addr.sv */
// Builds the 40-bit radio pipe address from the node address digit chain.
`default_nettype none

module tpr_pipe_addr (
  input  wire logic [15:0] node_address,
  input  wire logic [2:0]  level,
  input  wire logic [2:0]  pipe,
  output logic      [39:0] pipe_address,
  output logic             addr_ok
);

  logic [2:0] digit [0:4];
  logic [2:0] chain [0:7];
  logic [2:0] used;
  logic [2:0] pad;
  logic [2:0] pos;
  logic [7:0] byte_val [0:4];

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      digit[k] = tpr_pkg::digit_at(node_address, 3'(k));
    end
    chain[0] = 3'd0;
    for (int k = 0; k < 5; k++) begin
      chain[k+1] = tpr_pkg::mod6_add(chain[k], digit[k]);
    end
    chain[6] = 3'd0;
    chain[7] = 3'd0;

    if (pipe == 3'd0) begin
      used = level;
      pad  = 3'(tpr_pkg::DIGITS) - level;
    end else begin
      used = (level >= 3'd4) ? 3'd4 : level;
      pad  = 3'd4 - used;
    end

    addr_ok = 1'b1;
    for (int k = 0; k < 5; k++) begin
      if (3'(k) < used && digit[k] > 3'd5) begin
        addr_ok = 1'b0;
      end
    end

    for (int j = 0; j < 5; j++) begin
      pos = 3'(j) - pad + 3'd1;
      if (pipe != 3'd0 && j == 4) begin
        byte_val[j] = tpr_pkg::seg_byte(tpr_pkg::mod6_add(chain[used], pipe));
      end else if (3'(j) < pad) begin
        byte_val[j] = tpr_pkg::PAD_BYTE;
      end else begin
        byte_val[j] = tpr_pkg::seg_byte(chain[pos]);
      end
    end

    pipe_address = {byte_val[0], byte_val[1], byte_val[2], byte_val[3], byte_val[4]};
  end

endmodule

`default_nettype wire

/* sv/tpr_slots.sv */
// Child and member slot bookkeeping with the open flags.
`default_nettype none
`include "tree_packet_router_defines.svh"

module tpr_slots #(
  parameter int SLOTS = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  commit,
  input  wire tpr_pkg::slot_upd_t    upd,
  output tpr_pkg::slot_stat_t        stat
);

  logic [SLOTS-1:0] child_taken;
  logic [SLOTS-1:0] member_taken;
  logic             child_open;
  logic             member_open;
  logic [SLOTS-1:0] child_taken_next;
  logic [SLOTS-1:0] member_taken_next;

  always_comb begin
    stat.child_free  = '0;
    stat.member_free = '0;
    for (int e = SLOTS - 1; e >= 0; e--) begin
      if (!child_taken[e]) begin
        stat.child_free = tpr_pkg::SLOT_NUM_W'(e + 1);
      end
      if (!member_taken[e]) begin
        stat.member_free = tpr_pkg::SLOT_NUM_W'(e + 1);
      end
    end
    stat.child_open  = child_open && !(upd.child_req && stat.child_free == '0);
    stat.member_open = member_open && !(upd.member_req && stat.member_free == '0);

    child_taken_next  = child_taken;
    member_taken_next = member_taken;
    for (int e = 0; e < SLOTS; e++) begin
      if (upd.confirm && {1'b0, upd.slot} == 3'(e + 1)) begin
        if (upd.confirm_member) begin
          member_taken_next[e] = 1'b1;
        end else begin
          child_taken_next[e] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      child_taken  <= '0;
      member_taken <= '0;
      child_open   <= 1'b1;
      member_open  <= 1'b1;
    end else if (commit) begin
      child_taken  <= child_taken_next;
      member_taken <= member_taken_next;
      child_open   <= stat.child_open;
      member_open  <= stat.member_open;
    end
  end

  `TPR_ASSERT_NEXT(a_child_stays_closed, !child_open, !child_open, "child flag reopened")
  `TPR_ASSERT_NEXT(a_child_taken_kept, 1'b1, (child_taken & $past(child_taken)) == $past(child_taken), "child slot released")
  `TPR_ASSERT_SAME(a_child_closed_full, !child_open, &child_taken, "child flag closed with a free slot")
  `TPR_ASSERT_SAME(a_member_closed_full, !member_open, &member_taken, "member flag closed with a free slot")

endmodule

`default_nettype wire

/* sv/tree_packet_router.sv */
// A packet is held in the input register; its result is registered in the output
// register as the packet leaves. Throughput: one packet per cycle while results are
// taken; a waiting result holds a full input register, which then takes no new packet.
// The slot state is updated as a packet leaves the input register, so the next
// packet sees it. Reset clears the node address and level, all slots and opens
// both flags.
`default_nettype none

module tree_packet_router #(
  parameter int SLOTS     = 3,
  parameter int MAX_LEVEL = 5
) (
  input wire logic  clk,
  input wire logic  rst,
  tpr_in_if.sink    pkt,
  tpr_out_if.source result,
  tpr_cfg_if.sink   cfg
);

  logic [15:0]          node_address;
  logic [2:0]           node_level;
  logic                 s1_valid;
  tpr_pkg::item_t       s1;
  logic                 out_valid;
  tpr_pkg::result_t     out;
  tpr_pkg::result_t     res_next;
  tpr_pkg::slot_upd_t   upd;
  tpr_pkg::slot_stat_t  stat;
  logic                 fire;
  logic                 pkt_take;
  logic [2:0]           lvl;
  logic                 node_match;
  logic [15:0]          mask;
  logic [3:0]           mask_shift;
  logic [3:0]           grant_shift;
  logic                 in_tree;
  logic [2:0]           route_pipe;
  logic [39:0]          route_addr;
  logic                 route_ok;
  logic                 slot_ok;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= '0;
      node_level   <= '0;
    end else if (cfg.valid) begin
      case (tpr_pkg::cfg_reg_t'(cfg.index))
        tpr_pkg::REG_NODE_ADDRESS: node_address <= cfg.data;
        tpr_pkg::REG_NODE_LEVEL:   node_level   <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  assign fire      = s1_valid && (!out_valid || result.ready);
  assign pkt.ready = !s1_valid || fire;
  assign pkt_take  = pkt.valid && pkt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pkt_take) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_take) begin
      s1.cmd       <= tpr_pkg::cmd_t'(pkt.cmd);
      s1.dest_addr <= pkt.dest_addr;
      s1.src_addr  <= pkt.src_addr;
      s1.slot      <= pkt.slot;
    end
    if (fire) begin
      out <= res_next;
    end
  end

  assign lvl         = (node_level > 3'(MAX_LEVEL)) ? 3'(MAX_LEVEL) : node_level;
  assign node_match  = s1.dest_addr == node_address;
  assign mask_shift  = 4'(tpr_pkg::DIGITS * 3 - 3 * int'(lvl));
  assign grant_shift = 4'(tpr_pkg::DIGITS * 3 - 2 - 3 * int'(lvl));
  assign mask        = tpr_pkg::LEVEL_MASK_BASE << mask_shift;
  assign in_tree     = ((s1.dest_addr & mask) == node_address) &&
                       (int'(lvl) < tpr_pkg::DIGITS);
  assign route_pipe  = in_tree ? tpr_pkg::digit_at(s1.dest_addr, lvl) : 3'd0;
  assign slot_ok     = (s1.slot != 2'd0) && ({1'b0, s1.slot} <= 3'(SLOTS));

  assign upd.child_req      = (s1.cmd == tpr_pkg::CMD_CHILD_REQ) && (int'(lvl) < MAX_LEVEL);
  assign upd.member_req     = s1.cmd == tpr_pkg::CMD_MEMBER_REQ;
  assign upd.confirm        = (s1.cmd == tpr_pkg::CMD_CONFIRM) && node_match && slot_ok;
  assign upd.confirm_member = s1.src_addr == node_address;
  assign upd.slot           = s1.slot;

  tpr_pipe_addr u_pipe_addr (
    .node_address (node_address),
    .level        (lvl),
    .pipe         (route_pipe),
    .pipe_address (route_addr),
    .addr_ok      (route_ok)
  );

  tpr_slots #(
    .SLOTS (SLOTS)
  ) u_slots (
    .clk    (clk),
    .rst    (rst),
    .commit (fire),
    .upd    (upd),
    .stat   (stat)
  );

  always_comb begin
    res_next                = '0;
    res_next.action         = tpr_pkg::ACT_ADDR_ERROR;
    res_next.children_open  = stat.child_open;
    res_next.members_open   = stat.member_open;
    case (s1.cmd)
      tpr_pkg::CMD_CHILD_REQ: begin
        if (upd.child_req) begin
          if (stat.child_free == '0) begin
            res_next.action = tpr_pkg::ACT_NO_SLOT;
          end else begin
            res_next.action        = tpr_pkg::ACT_GRANT;
            res_next.pipe_address  = tpr_pkg::BROADCAST_PIPE;
            res_next.granted_addr  = node_address |
                                     16'(32'(stat.child_free) << grant_shift);
            res_next.granted_level = lvl + 3'd1;
          end
        end
      end
      tpr_pkg::CMD_MEMBER_REQ: begin
        if (stat.member_free == '0) begin
          res_next.action = tpr_pkg::ACT_NO_SLOT;
        end else begin
          res_next.action         = tpr_pkg::ACT_GRANT;
          res_next.pipe_address   = tpr_pkg::BROADCAST_PIPE;
          res_next.granted_addr   = node_address;
          res_next.granted_level  = lvl;
          res_next.granted_member = stat.member_free[1:0];
        end
      end
      default: begin
        if (s1.cmd == tpr_pkg::CMD_CONFIRM && node_match) begin
          if (slot_ok) begin
            res_next.action = tpr_pkg::ACT_CONFIRMED;
          end
        end else if (node_match) begin
          res_next.action = tpr_pkg::ACT_LOCAL;
        end else if (route_pipe <= 3'd5 && route_ok) begin
          res_next.action       = (route_pipe != 3'd0) ? tpr_pkg::ACT_CHILD :
                                                         tpr_pkg::ACT_PARENT;
          res_next.pipe_index   = route_pipe;
          res_next.pipe_address = route_addr;
        end
      end
    endcase
  end

  assign result.valid          = out_valid;
  assign result.action         = out.action;
  assign result.pipe_index     = out.pipe_index;
  assign result.pipe_address   = out.pipe_address;
  assign result.granted_addr   = out.granted_addr;
  assign result.granted_level  = out.granted_level;
  assign result.granted_member = out.granted_member;
  assign result.children_open  = out.children_open;
  assign result.members_open   = out.members_open;

endmodule

`default_nettype wire
